// ===== rtl/atclp_pkg.sv =====
package atclp_pkg;

  localparam int MAX_CMDS_DEF = 16;
  localparam int NAME_MAX_DEF = 16;
  localparam int LINE_MAX_DEF = 64;

  // width used for position compares, holds LINE_MAX + a few
  localparam int CMP_W = 10;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_A  = 8'h61;
  localparam logic [7:0] CH_T  = 8'h74;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_QM = 8'h3F;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UZ = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'd32;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_NAME = 1'b1;

  localparam logic [2:0] K_EXEC  = 3'd0;
  localparam logic [2:0] K_QUERY = 3'd1;
  localparam logic [2:0] K_TEST  = 3'd2;
  localparam logic [2:0] K_SET   = 3'd3;
  localparam logic [2:0] K_NOHIT = 3'd4;
  localparam logic [2:0] K_OVF   = 3'd5;

  typedef struct packed {
    logic       shift;
    logic       wr_en;
    logic [7:0] wr_data;
  } lc_ctl_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PUT2   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DECIDE = 6'b001000,
    S_EMIT   = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= CH_UA && b <= CH_UZ) r = b + CASE_OFS;
    return r;
  endfunction

endpackage

// ===== rtl/at_command_line_parser.sv =====
// AT command line parser.
// Input channel (in_valid/in_ready) takes one request per item: a received
// character (in_op 0) or a name-table byte write (in_op 1, in_entry,
// in_position). Characters collect in a ring of byte cells; CR LF ends a line.
// Config channel (cfg_valid/cfg_ready) writes active_commands, always ready.
// Output channel (out_valid/out_ready) gives the result of each line:
// execute, query, test, no match, overflow, or one set per argument byte.
// A lone CR followed by another character puts the CR, then that character
// from S_PUT2. At end of line the ring is rotated once per table entry
// tried, then rotated again up to the last argument byte for a set.
// in_ready is low while a line end is worked on.
// Reset clears the line state, name lengths and active_commands; line bytes
// and name bytes are not cleared. A stalled receiver holds the output
// register; the set walk and the result step wait, and a pending result
// never blocks a new character once the line is done.
module at_command_line_parser #(
  parameter int MAX_CMDS = atclp_pkg::MAX_CMDS_DEF,
  parameter int NAME_MAX = atclp_pkg::NAME_MAX_DEF,
  parameter int LINE_MAX = atclp_pkg::LINE_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_char_byte,
  input  logic [3:0] in_entry,
  input  logic [3:0] in_position,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [3:0] out_cmd_index,
  output logic [7:0] out_arg_byte,
  output logic       out_has_arg,
  output logic       out_last
);

  localparam int NENT = (MAX_CMDS < 16) ? MAX_CMDS : 16;
  localparam int EIW  = (NENT > 1) ? $clog2(NENT) : 1;
  localparam int NPW  = $clog2(NAME_MAX);
  localparam int NAW  = $clog2(NENT * NAME_MAX);
  localparam int LW   = $clog2(LINE_MAX + 1);
  localparam int JW   = $clog2(LINE_MAX);
  localparam int CW   = atclp_pkg::CMP_W;

  atclp_pkg::state_t state_r, state_nxt;

  logic [4:0]    active_r;
  logic [LW-1:0] len_r, len_nxt;
  logic          pcr_r, pcr_nxt, eqs_r, eqs_nxt, pra_r, pra_nxt;
  logic          atf_r, atf_nxt, ovf_r, ovf_nxt;
  logic [7:0]    hold_r, hold_nxt;
  logic [4:0]    e_r, e_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic          ok_r, ok_nxt, neq_r, neq_nxt;
  logic [7:0]    bp_r, bp_nxt, bp1_r, bp1_nxt;
  logic [2:0]    rkind_r, rkind_nxt;
  logic [3:0]    ridx_r, ridx_nxt;

  logic [4:0]    nlen_r [NENT];
  logic [7:0]    ntab [NENT*NAME_MAX];
  logic [7:0]    nrd_r;
  logic [NAW-1:0] raddr, waddr;

  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_kind_r, out_kind_nxt;
  logic [3:0] out_idx_r, out_idx_nxt;
  logic [7:0] out_arg_r, out_arg_nxt;
  logic       out_has_r, out_has_nxt, out_last_r, out_last_nxt;

  atclp_pkg::lc_ctl_t lc;
  logic [7:0] head;

  logic       in_acc, slot_free, name_wr, put_en, line_done;
  logic [7:0] put_b, pb, lw;
  logic [4:0] nact, cur_len;
  logic [CW-1:0] jj, pp, ll, kidx;
  logic       in_cmp, fits, emit_byte;

  assign in_acc    = in_valid && in_ready;
  assign in_ready  = (state_r == atclp_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || out_ready;
  assign nact      = (active_r < 5'(NENT)) ? active_r : 5'(NENT);

  assign name_wr = in_acc && in_op == atclp_pkg::OP_NAME &&
                   32'(in_entry) < MAX_CMDS && 32'(in_position) < NAME_MAX;
  assign waddr   = NAW'(in_entry) * NAW'(NAME_MAX) + NAW'(in_position);

  assign cur_len = nlen_r[e_r[EIW-1:0]];
  assign jj      = CW'(j_r);
  assign pp      = CW'(cur_len) + CW'(2);
  assign ll      = CW'(len_r);
  assign kidx    = jj - CW'(1);
  assign raddr   = NAW'(e_r[EIW-1:0]) * NAW'(NAME_MAX) + NAW'(kidx[NPW-1:0]);
  assign in_cmp  = jj >= CW'(2) && jj < pp;
  assign lw      = neq_r ? nrd_r : atclp_pkg::to_lower(nrd_r);
  assign fits    = ll >= pp && ok_r;
  assign emit_byte = jj >= pp + CW'(1) && jj < ll;

  // name table and lengths
  always_ff @(posedge clk) begin
    if (name_wr) ntab[waddr] <= in_char_byte;
    nrd_r <= ntab[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NENT; i++) nlen_r[i] <= '0;
    end else if (name_wr) begin
      nlen_r[in_entry[EIW-1:0]] <= 5'(in_position) + 5'd1;
    end
  end

  // put byte into the line
  always_comb begin
    pb = put_b;
    if (!eqs_r) pb = atclp_pkg::to_lower(put_b);
  end

  always_comb begin
    state_nxt = state_r;
    len_nxt = len_r; pcr_nxt = pcr_r; eqs_nxt = eqs_r; pra_nxt = pra_r;
    atf_nxt = atf_r; ovf_nxt = ovf_r; hold_nxt = hold_r;
    e_nxt = e_r; j_nxt = j_r; ok_nxt = ok_r; neq_nxt = neq_r;
    bp_nxt = bp_r; bp1_nxt = bp1_r; rkind_nxt = rkind_r; ridx_nxt = ridx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt = out_kind_r; out_idx_nxt = out_idx_r; out_arg_nxt = out_arg_r;
    out_has_nxt = out_has_r; out_last_nxt = out_last_r;
    put_en = 1'b0; put_b = in_char_byte; line_done = 1'b0;
    lc.shift = 1'b0;

    case (state_r)
      atclp_pkg::S_IDLE: begin
        if (in_acc && in_op == atclp_pkg::OP_CHAR) begin
          if (!pcr_r) begin
            if (in_char_byte == atclp_pkg::CH_CR) pcr_nxt = 1'b1;
            else put_en = 1'b1;
          end else if (in_char_byte == atclp_pkg::CH_CR) begin
            put_en = 1'b1;
            put_b  = atclp_pkg::CH_CR;
          end else if (in_char_byte != atclp_pkg::CH_LF) begin
            put_en   = 1'b1;
            put_b    = atclp_pkg::CH_CR;
            hold_nxt = in_char_byte;
            pcr_nxt  = 1'b0;
            state_nxt = atclp_pkg::S_PUT2;
          end else if (ovf_r) begin
            rkind_nxt = atclp_pkg::K_OVF;
            ridx_nxt  = '0;
            state_nxt = atclp_pkg::S_RESULT;
          end else if (!atf_r || nact == 5'd0) begin
            rkind_nxt = atclp_pkg::K_NOHIT;
            ridx_nxt  = '0;
            state_nxt = atclp_pkg::S_RESULT;
          end else begin
            e_nxt = '0; j_nxt = '0; ok_nxt = 1'b1; neq_nxt = 1'b0;
            state_nxt = atclp_pkg::S_SCAN;
          end
        end
      end
      atclp_pkg::S_PUT2: begin
        put_en = 1'b1;
        put_b  = hold_r;
        state_nxt = atclp_pkg::S_IDLE;
      end
      atclp_pkg::S_SCAN: begin
        lc.shift = 1'b1;
        if (in_cmp) begin
          if (head != lw) ok_nxt = 1'b0;
          if (!neq_r && lw == atclp_pkg::CH_EQ) neq_nxt = 1'b1;
        end
        if (jj == pp) bp_nxt = head;
        if (jj == pp + CW'(1)) bp1_nxt = head;
        j_nxt = j_r + JW'(1);
        if (j_r == JW'(LINE_MAX - 1)) begin
          j_nxt = '0;
          state_nxt = atclp_pkg::S_DECIDE;
        end
      end
      atclp_pkg::S_DECIDE: begin
        ridx_nxt  = e_r[3:0];
        state_nxt = atclp_pkg::S_RESULT;
        if (fits && ll == pp) begin
          rkind_nxt = atclp_pkg::K_EXEC;
        end else if (fits && ll == pp + CW'(1) && bp_r == atclp_pkg::CH_QM) begin
          rkind_nxt = atclp_pkg::K_QUERY;
        end else if (fits && ll == pp + CW'(2) && bp_r == atclp_pkg::CH_EQ &&
                     bp1_r == atclp_pkg::CH_QM) begin
          rkind_nxt = atclp_pkg::K_TEST;
        end else if (fits && ll >= pp + CW'(2) && bp_r == atclp_pkg::CH_EQ) begin
          j_nxt = '0;
          state_nxt = atclp_pkg::S_EMIT;
        end else if (e_r + 5'd1 == nact) begin
          rkind_nxt = atclp_pkg::K_NOHIT;
          ridx_nxt  = '0;
        end else begin
          e_nxt = e_r + 5'd1;
          ok_nxt = 1'b1; neq_nxt = 1'b0;
          state_nxt = atclp_pkg::S_SCAN;
        end
      end
      atclp_pkg::S_EMIT: begin
        if (!emit_byte || slot_free) begin
          lc.shift = 1'b1;
          j_nxt = j_r + JW'(1);
          if (emit_byte) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = atclp_pkg::K_SET;
            out_idx_nxt   = e_r[3:0];
            out_arg_nxt   = head;
            out_has_nxt   = 1'b1;
            out_last_nxt  = (jj + CW'(1) == ll);
            if (jj + CW'(1) == ll) begin
              line_done = 1'b1;
              state_nxt = atclp_pkg::S_IDLE;
            end
          end
        end
      end
      atclp_pkg::S_RESULT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = rkind_r;
          out_idx_nxt   = ridx_r;
          out_arg_nxt   = '0;
          out_has_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          line_done = 1'b1;
          state_nxt = atclp_pkg::S_IDLE;
        end
      end
      default: state_nxt = atclp_pkg::S_IDLE;
    endcase

    lc.wr_en   = 1'b0;
    lc.wr_data = pb;
    if (put_en) begin
      if (len_r >= LW'(LINE_MAX)) begin
        ovf_nxt = 1'b1;
      end else begin
        if (!eqs_r && pb == atclp_pkg::CH_EQ) eqs_nxt = 1'b1;
        if (pra_r && pb == atclp_pkg::CH_T) atf_nxt = 1'b1;
        pra_nxt = (pb == atclp_pkg::CH_A);
        lc.wr_en = 1'b1;
        len_nxt  = len_r + LW'(1);
      end
    end
    if (line_done) begin
      len_nxt = '0; pcr_nxt = 1'b0; eqs_nxt = 1'b0; pra_nxt = 1'b0;
      atf_nxt = 1'b0; ovf_nxt = 1'b0;
    end
  end

  atclp_line_chain #(.LINE_MAX(LINE_MAX)) u_chain (
    .clk   (clk),
    .ctl   (lc),
    .wr_idx(len_r[JW-1:0]),
    .head  (head)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= atclp_pkg::S_IDLE;
      active_r <= '0;
      len_r <= '0; pcr_r <= 1'b0; eqs_r <= 1'b0; pra_r <= 1'b0;
      atf_r <= 1'b0; ovf_r <= 1'b0;
      e_r <= '0; j_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) active_r <= cfg_data;
      len_r <= len_nxt; pcr_r <= pcr_nxt; eqs_r <= eqs_nxt; pra_r <= pra_nxt;
      atf_r <= atf_nxt; ovf_r <= ovf_nxt;
      e_r <= e_nxt; j_r <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt; ok_r <= ok_nxt; neq_r <= neq_nxt;
    bp_r <= bp_nxt; bp1_r <= bp1_nxt; rkind_r <= rkind_nxt; ridx_r <= ridx_nxt;
    out_kind_r <= out_kind_nxt; out_idx_r <= out_idx_nxt; out_arg_r <= out_arg_nxt;
    out_has_r <= out_has_nxt; out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_cmd_index = out_idx_r;
  assign out_arg_byte  = out_arg_r;
  assign out_has_arg   = out_has_r;
  assign out_last      = out_last_r;

  a_scan_needs_at: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == atclp_pkg::S_SCAN |-> atf_r && !ovf_r)
    else $error("table walk on a line without at");

  a_arg_only_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_has_r |-> out_kind_r == atclp_pkg::K_SET)
    else $error("argument byte on a non-set result");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(LINE_MAX))
    else $error("line length beyond buffer");

  a_emit_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == atclp_pkg::S_EMIT && state_nxt == atclp_pkg::S_IDLE
    |=> out_valid_r && out_last_r)
    else $error("set stream ended without last");

endmodule

// ===== rtl/atclp_cell.sv =====
module atclp_cell (
  input  logic       clk,
  input  logic       ld,
  input  logic [7:0] din,
  input  logic       shift,
  input  logic [7:0] nbr,
  output logic [7:0] q
);

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (ld) begin
      byte_r <= din;
    end else if (shift) begin
      byte_r <= nbr;
    end
  end

  assign q = byte_r;

endmodule

// ===== rtl/atclp_line_chain.sv =====
module atclp_line_chain #(
  parameter int LINE_MAX = atclp_pkg::LINE_MAX_DEF
) (
  input  logic                        clk,
  input  atclp_pkg::lc_ctl_t          ctl,
  input  logic [$clog2(LINE_MAX)-1:0] wr_idx,
  output logic [7:0]                  head
);

  logic [7:0] q [LINE_MAX];

  // ring: cell i takes cell i+1, last cell takes the head
  for (genvar i = 0; i < LINE_MAX; i++) begin : g_cell
    atclp_cell u_cell (
      .clk  (clk),
      .ld   (ctl.wr_en && (wr_idx == ($clog2(LINE_MAX))'(i))),
      .din  (ctl.wr_data),
      .shift(ctl.shift),
      .nbr  (q[(i + 1) % LINE_MAX]),
      .q    (q[i])
    );
  end

  assign head = q[0];

endmodule

// ===== tb/at_command_line_parser_test.sv =====
module at_command_line_parser_test;

  localparam int LINE_CAP = 64;
  localparam int NAME_CAP = 16;
  localparam int TABLE_CAP = 16;

  typedef struct {
    logic [2:0] kind;
    logic [3:0] cmd_index;
    logic [7:0] arg_byte;
    logic       has_arg;
    logic       last;
  } line_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_op = atclp_pkg::OP_CHAR;
  logic [7:0] in_char_byte = 8'd0;
  logic [3:0] in_entry = 4'd0;
  logic [3:0] in_position = 4'd0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_data = 5'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_kind;
  logic [3:0] out_cmd_index;
  logic [7:0] out_arg_byte;
  logic       out_has_arg;
  logic       out_last;

  at_command_line_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_char_byte(in_char_byte), .in_entry(in_entry), .in_position(in_position),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_cmd_index(out_cmd_index), .out_arg_byte(out_arg_byte),
    .out_has_arg(out_has_arg), .out_last(out_last)
  );

  // parser state mirrored for prediction
  logic [7:0] line_buf [LINE_CAP];
  int         line_len;
  logic       cr_held, eq_in_line, last_was_a, saw_at, too_long;
  logic [7:0] cmd_names [TABLE_CAP][NAME_CAP];
  int         cmd_len [TABLE_CAP];
  int         written_prefix [TABLE_CAP];
  int         cmds_in_use;

  line_result_t expected_results[$];
  int         mismatches = 0;
  int         results_seen = 0;
  int         items_sent = 0;
  bit         idling = 1'b1;
  int         rx_hold = 0;
  int         rx_wait = 0;

  initial forever #6 clk = ~clk;

  initial begin
    #(12 * 1_500_000);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void push_result(logic [2:0] k, int idx, logic [7:0] arg,
                                      logic has, logic lst);
    line_result_t r;
    r.kind = k;
    r.cmd_index = idx[3:0];
    r.arg_byte = arg;
    r.has_arg = has;
    r.last = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void store_char(logic [7:0] b);
    if (line_len >= LINE_CAP) begin
      too_long = 1'b1;
      return;
    end
    if (!eq_in_line) begin
      if (b >= "A" && b <= "Z") b = b + 8'd32;
      if (b == atclp_pkg::CH_EQ) eq_in_line = 1'b1;
    end
    if (last_was_a && b == atclp_pkg::CH_T) saw_at = 1'b1;
    last_was_a = (b == atclp_pkg::CH_A);
    line_buf[line_len] = b;
    line_len++;
  endfunction

  function automatic bit name_matches(int e);
    bit         eq;
    logic [7:0] nb;
    eq = 1'b0;
    if (line_len < 2 + cmd_len[e]) return 1'b0;
    for (int k = 0; k < cmd_len[e]; k++) begin
      nb = cmd_names[e][k];
      if (!eq) begin
        if (nb >= "A" && nb <= "Z") nb = nb + 8'd32;
        if (nb == atclp_pkg::CH_EQ) eq = 1'b1;
      end
      if (line_buf[2 + k] != nb) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void close_line();
    int n, p;
    n = cmds_in_use > TABLE_CAP ? TABLE_CAP : cmds_in_use;
    if (too_long) begin
      push_result(atclp_pkg::K_OVF, 0, 8'd0, 1'b0, 1'b1);
      return;
    end
    if (saw_at) begin
      for (int e = 0; e < n; e++) begin
        p = 2 + cmd_len[e];
        if (!name_matches(e)) continue;
        if (line_len == p) begin
          push_result(atclp_pkg::K_EXEC, e, 8'd0, 1'b0, 1'b1);
          return;
        end
        if (line_len == p + 1 && line_buf[p] == atclp_pkg::CH_QM) begin
          push_result(atclp_pkg::K_QUERY, e, 8'd0, 1'b0, 1'b1);
          return;
        end
        if (line_len == p + 2 && line_buf[p] == atclp_pkg::CH_EQ &&
            line_buf[p + 1] == atclp_pkg::CH_QM) begin
          push_result(atclp_pkg::K_TEST, e, 8'd0, 1'b0, 1'b1);
          return;
        end
        if (line_len >= p + 2 && line_buf[p] == atclp_pkg::CH_EQ) begin
          for (int i = p + 1; i < line_len; i++)
            push_result(atclp_pkg::K_SET, e, line_buf[i], 1'b1, (i + 1 == line_len));
          return;
        end
      end
    end
    push_result(atclp_pkg::K_NOHIT, 0, 8'd0, 1'b0, 1'b1);
  endfunction

  function automatic void predict_request(logic op, logic [7:0] c, int e, int pos);
    if (op == atclp_pkg::OP_NAME) begin
      cmd_names[e][pos] = c;
      cmd_len[e] = pos + 1;
      if (pos == written_prefix[e]) written_prefix[e] = pos + 1;
      return;
    end
    if (!cr_held) begin
      if (c == atclp_pkg::CH_CR) cr_held = 1'b1;
      else store_char(c);
      return;
    end
    if (c == atclp_pkg::CH_CR) begin
      store_char(atclp_pkg::CH_CR);
      return;
    end
    if (c != atclp_pkg::CH_LF) begin
      store_char(atclp_pkg::CH_CR);
      store_char(c);
      cr_held = 1'b0;
      return;
    end
    close_line();
    line_len = 0;
    cr_held = 1'b0;
    eq_in_line = 1'b0;
    last_was_a = 1'b0;
    saw_at = 1'b0;
    too_long = 1'b0;
  endfunction

  task automatic send_item(logic op, logic [7:0] c, int e, int pos);
    int gap;
    gap = idling ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_char_byte <= c;
    in_entry <= e[3:0];
    in_position <= pos[3:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(op, c, e, pos);
    items_sent++;
  endtask

  task automatic send_char(logic [7:0] c);
    send_item(atclp_pkg::OP_CHAR, c, $urandom_range(0, 15), $urandom_range(0, 15));
  endtask

  task automatic send_crlf();
    send_char(atclp_pkg::CH_CR);
    send_char(atclp_pkg::CH_LF);
  endtask

  task automatic send_line(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_crlf();
  endtask

  task automatic write_name(int e, string s);
    for (int i = 0; i < s.len(); i++) send_item(atclp_pkg::OP_NAME, s[i], e, i);
  endtask

  // wait for the block to drain before touching the register
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_cfg(logic [4:0] v);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cmds_in_use = int'(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver ready: long hold, per-result wait, else ready
  initial forever begin
    @(negedge clk);
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    line_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      rx_wait = idling ? $urandom_range(0, 8) : 0;
      if (expected_results.size() == 0) begin
        $error("unexpected result kind %0d index %0d", out_kind, out_cmd_index);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_kind !== want.kind) begin
          $error("kind expected %0d actual %0d", want.kind, out_kind);
          mismatches++;
        end
        if (out_cmd_index !== want.cmd_index) begin
          $error("cmd_index expected %0d actual %0d", want.cmd_index, out_cmd_index);
          mismatches++;
        end
        if (out_arg_byte !== want.arg_byte) begin
          $error("arg_byte expected %0d actual %0d", want.arg_byte, out_arg_byte);
          mismatches++;
        end
        if (out_has_arg !== want.has_arg) begin
          $error("has_arg expected %0d actual %0d", want.has_arg, out_has_arg);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $error("last expected %0d actual %0d", want.last, out_last);
          mismatches++;
        end
      end
    end
  end

  task automatic test_directed_forms();
    write_name(0, "I");
    write_name(1, "+CMGF");
    write_name(3, "x=Y");
    write_cfg(5'd4);
    send_line("AT");
    send_line("ATI");
    send_line("at+cmgf?");
    send_line("AT+CMGF=?");
    send_line("atx=Y=5");
    send_char("A"); send_char("T"); send_char(atclp_pkg::CH_CR); send_char("I"); send_crlf();
    send_char("A"); send_char("T"); send_char("I"); send_char(atclp_pkg::CH_CR); send_crlf();
    send_char("A"); send_char("T"); send_char(atclp_pkg::CH_LF); send_crlf();
    send_char("A"); send_char("T"); send_char(8'h00); send_crlf();
    send_line("AT+CMGF=");
  endtask

  task automatic test_overflow();
    // one byte more than the line holds
    send_char("a"); send_char("t");
    for (int i = 0; i < 63; i++) send_char("z");
    send_crlf();
  endtask

  task automatic test_cfg_extremes();
    write_name(15, "ABCDEFGHIJKLMNOP");
    write_cfg(5'd0);
    send_line("ATI");
    write_cfg(5'd31);
    send_line("atabcdefghijklmnop?");
    write_cfg(5'd17);
    send_line("AT+CMGF?");
  endtask

  task automatic test_backpressure();
    settle();
    rx_hold = 3000;
    for (int i = 0; i < 2; i++) send_line("AT+CMGF=12");
  endtask

  task automatic random_line();
    int   e, form, n;
    logic [7:0] b;
    e = $urandom_range(0, 15);
    if ($urandom_range(0, 11) == 0) begin
      n = $urandom_range(0, 10);
      for (int i = 0; i < n; i++) send_char(8'($urandom_range(0, 255)));
    end else if ($urandom_range(0, 14) == 0) begin
      n = $urandom_range(60, 72);
      send_char("a"); send_char("t");
      for (int i = 0; i < n; i++) send_char(8'($urandom_range(0, 255)));
    end else begin
      send_char($urandom_range(0, 1) ? "A" : "a");
      send_char($urandom_range(0, 1) ? "T" : "t");
      for (int k = 0; k < cmd_len[e]; k++) send_char(cmd_names[e][k]);
      form = $urandom_range(0, 4);
      if (form == 1) send_char(atclp_pkg::CH_QM);
      if (form == 2) begin
        send_char(atclp_pkg::CH_EQ); send_char(atclp_pkg::CH_QM);
      end
      if (form >= 3) begin
        if (form == 3) send_char(atclp_pkg::CH_EQ);
        n = $urandom_range(0, 9) == 0 ? $urandom_range(20, 58) : $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom_range(0, 255));
          send_char(b);
        end
      end
    end
    send_crlf();
  endtask

  task automatic random_name_write();
    int e, n, pos;
    e = $urandom_range(0, 15);
    if ($urandom_range(0, 1)) begin
      n = $urandom_range(1, 16);
      for (int i = 0; i < n; i++)
        send_item(atclp_pkg::OP_NAME, 8'($urandom_range(8'h21, 8'hFF)), e, i);
    end else begin
      pos = $urandom_range(0, written_prefix[e] > 15 ? 15 : written_prefix[e]);
      send_item(atclp_pkg::OP_NAME, 8'($urandom_range(8'h21, 8'hFF)), e, pos);
    end
  endtask

  task automatic test_random_traffic();
    logic [4:0] v;
    int lines;
    lines = 0;
    while (items_sent < 250) begin
      if (lines % 12 == 0) begin
        case ($urandom_range(0, 3))
          0: v = 5'd0;
          1: v = 5'd31;
          2: v = 5'd16;
          default: v = 5'($urandom_range(1, 31));
        endcase
        write_cfg(v);
        idling = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 7) == 0) random_name_write();
      else random_line();
      lines++;
    end
  endtask

  initial begin
    line_len = 0;
    cr_held = 0; eq_in_line = 0; last_was_a = 0; saw_at = 0; too_long = 0;
    cmds_in_use = 0;
    for (int e = 0; e < TABLE_CAP; e++) begin
      cmd_len[e] = 0;
      written_prefix[e] = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_forms();
    test_overflow();
    test_cfg_extremes();
    test_backpressure();
    test_random_traffic();
    settle();
    repeat (100) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/atclp_pkg.sv
rtl/atclp_cell.sv
rtl/atclp_line_chain.sv
rtl/at_command_line_parser.sv
tb/at_command_line_parser_test.sv
